// ----- hw/rtl/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, codes and constants of the shower position correction block.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int TABLE_AW    = 7;
  localparam int TABLE_DEPTH = 128;
  localparam int VAL_W       = 16;
  localparam int SEG_W       = 4;
  localparam int QDEPTH      = 2;
  localparam int DIV_NW      = 61;
  localparam int DIV_DW      = 44;
  localparam int DIV_CW      = 6;

  localparam logic signed [16:0] HALF_Q16 = 17'sd32768;

  localparam logic signed [19:0] RST_SEED_X_MIN = -20'sd98304;
  localparam logic signed [19:0] RST_SEED_X_MAX = 20'sd98304;
  localparam logic signed [19:0] RST_SEED_Y_MIN = -20'sd42598;
  localparam logic signed [19:0] RST_SEED_Y_MAX = 20'sd42598;
  localparam logic signed [15:0] RST_MOMENT_MIN = -16'sd4096;
  localparam logic signed [15:0] RST_MOMENT_MAX = 16'sd4096;
  localparam logic [15:0]        RST_CELL_WIDTH = 16'd2818;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_SEED   = 2'd1,
    STAT_MOMENT = 2'd2,
    STAT_ZERO   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_SEED_X_MIN   = 3'd0,
    CFG_SEED_X_MAX   = 3'd1,
    CFG_SEED_Y_MIN   = 3'd2,
    CFG_SEED_Y_MAX   = 3'd3,
    CFG_MOMENT_MIN   = 3'd4,
    CFG_MOMENT_MAX   = 3'd5,
    CFG_CELL_WIDTH_X = 3'd6,
    CFG_CELL_WIDTH_Y = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic                mode;
    logic [6:0]          table_index;
    logic [15:0]         profile_x_value;
    logic [15:0]         profile_y_value;
    logic signed [19:0]  block_x;
    logic signed [19:0]  block_y;
    logic [19:0]         block_energy;
    logic                last_block;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0]  corrected_x;
    logic signed [19:0]  corrected_y;
    logic [1:0]          status;
  } out_item_t;

  typedef struct packed {
    logic signed [19:0]  seed_x_min;
    logic signed [19:0]  seed_x_max;
    logic signed [19:0]  seed_y_min;
    logic signed [19:0]  seed_y_max;
    logic signed [15:0]  moment_min;
    logic signed [15:0]  moment_max;
    logic [15:0]         cell_width_x;
    logic [15:0]         cell_width_y;
  } cfg_t;

  typedef struct packed {
    logic                is_write;
    logic [TABLE_AW-1:0] table_index;
    logic [VAL_W-1:0]    px;
    logic [VAL_W-1:0]    py;
    logic signed [47:0]  sum_x;
    logic signed [47:0]  sum_y;
    logic [27:0]         energy_sum;
    logic signed [19:0]  seed_x;
    logic signed [19:0]  seed_y;
  } job_t;

  typedef struct packed {
    logic                we;
    logic [TABLE_AW-1:0] waddr;
    logic [VAL_W-1:0]    wdata_x;
    logic [VAL_W-1:0]    wdata_y;
    logic [TABLE_AW-1:0] raddr_x;
    logic [TABLE_AW-1:0] raddr_y;
  } tbl_port_t;

  function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
    logic signed [19:0] r;
    if (v > 21'sd524287) begin
      r = 20'sd524287;
    end else if (v < -21'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/shower_position_correction_top.sv -----
// ----------------------------------------------------------------------------
// shower_position_correction_top
// Calorimeter shower position correction from cumulative shower profiles.
//
// Input channel (in_valid/in_ready/in_data): mode 0 requests write one x and
// y profile entry, mode 1 requests carry one block of a cluster. The front
// takes no new request until done with the last and accumulates the cluster
// sums and seed. Table writes and finished clusters go via a 2-entry queue
// to the back end, which applies writes in order and computes the correction.
// Result channel (out_valid/out_ready/out_data): one result per last block,
// computed by eight passes of the shared radix-2 divider (segments, moments,
// bins, interpolation) plus table reads and the final multiply. Early status
// results skip the divider passes that remain.
// The result stays in the output register while the receiver stalls; the
// front keeps taking blocks until the queue fills.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once.
// Reset (rst_n, synchronous) loads register defaults and clears the cluster
// state and queue; the profile tables are not cleared.
// ----------------------------------------------------------------------------
module shower_position_correction_top
  import spc_pkg::*;
#(
  parameter int SEGMENTS_X   = 1,
  parameter int SEGMENTS_Y   = 1,
  parameter int PROFILE_BINS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  cfg_t             cfg_r;
  logic             q_push, q_full, q_pop, q_empty;
  job_t             q_push_data, q_pop_data;
  tbl_port_t        tbl;
  logic [VAL_W-1:0] rdata_x, rdata_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_x_min   <= RST_SEED_X_MIN;
      cfg_r.seed_x_max   <= RST_SEED_X_MAX;
      cfg_r.seed_y_min   <= RST_SEED_Y_MIN;
      cfg_r.seed_y_max   <= RST_SEED_Y_MAX;
      cfg_r.moment_min   <= RST_MOMENT_MIN;
      cfg_r.moment_max   <= RST_MOMENT_MAX;
      cfg_r.cell_width_x <= RST_CELL_WIDTH;
      cfg_r.cell_width_y <= RST_CELL_WIDTH;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SEED_X_MIN:   cfg_r.seed_x_min   <= cfg_wdata;
        CFG_SEED_X_MAX:   cfg_r.seed_x_max   <= cfg_wdata;
        CFG_SEED_Y_MIN:   cfg_r.seed_y_min   <= cfg_wdata;
        CFG_SEED_Y_MAX:   cfg_r.seed_y_max   <= cfg_wdata;
        CFG_MOMENT_MIN:   cfg_r.moment_min   <= cfg_wdata[15:0];
        CFG_MOMENT_MAX:   cfg_r.moment_max   <= cfg_wdata[15:0];
        CFG_CELL_WIDTH_X: cfg_r.cell_width_x <= cfg_wdata[15:0];
        CFG_CELL_WIDTH_Y: cfg_r.cell_width_y <= cfg_wdata[15:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  spc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  spc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  spc_ram #(.W(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (tbl.we),
    .waddr (tbl.waddr),
    .wdata (tbl.wdata_x),
    .raddr (tbl.raddr_x),
    .rdata (rdata_x)
  );

  spc_ram #(.W(VAL_W), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (tbl.we),
    .waddr (tbl.waddr),
    .wdata (tbl.wdata_y),
    .raddr (tbl.raddr_y),
    .rdata (rdata_y)
  );

  spc_back #(
    .SEGMENTS_X   (SEGMENTS_X),
    .SEGMENTS_Y   (SEGMENTS_Y),
    .PROFILE_BINS (PROFILE_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_pop_data),
    .tbl       (tbl),
    .rdata_x   (rdata_x),
    .rdata_y   (rdata_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request queue underflow");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front took a request while busy");

endmodule

// ----- hw/rtl/spc_ram.sv -----
// ----------------------------------------------------------------------------
// spc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/spc_queue.sv -----
// ----------------------------------------------------------------------------
// spc_queue
// Short request queue between the accumulating front and the back end.
// ----------------------------------------------------------------------------
module spc_queue
  import spc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int QAW = $clog2(QDEPTH);

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r;
  logic [QAW-1:0]   rp_r;
  logic [QAW:0]     count_r;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= push_data;
        wp_r        <= (wp_r == QAW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/spc_front.sv -----
// ----------------------------------------------------------------------------
// spc_front
// Accepts requests, accumulates energy-weighted sums and the seed block, and
// queues table writes and finished clusters for the back end.
// ----------------------------------------------------------------------------
module spc_front
  import spc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_data,
  input  logic     q_full
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC} fstate_t;

  fstate_t            state_r;
  in_item_t           item_r;
  logic signed [40:0] prodx_r, prody_r;
  logic signed [47:0] wsx_r, wsy_r;
  logic [27:0]        esum_r;
  logic [19:0]        seed_e_r;
  logic signed [19:0] seed_x_r, seed_y_r;
  logic               first_r;

  logic signed [47:0] wsx_nxt, wsy_nxt;
  logic [27:0]        esum_nxt;
  logic               take;
  logic signed [19:0] seed_x_nxt, seed_y_nxt;

  assign in_ready   = (state_r == F_IDLE) && !q_full;
  assign wsx_nxt    = wsx_r + 48'(prodx_r);
  assign wsy_nxt    = wsy_r + 48'(prody_r);
  assign esum_nxt   = esum_r + 28'(item_r.block_energy);
  assign take       = first_r || (item_r.block_energy > seed_e_r);
  assign seed_x_nxt = take ? item_r.block_x : seed_x_r;
  assign seed_y_nxt = take ? item_r.block_y : seed_y_r;

  assign push = (state_r == F_ACC) && (!item_r.mode || item_r.last_block);

  always_comb begin
    push_data             = '0;
    push_data.is_write    = !item_r.mode;
    push_data.table_index = item_r.table_index;
    push_data.px          = item_r.profile_x_value;
    push_data.py          = item_r.profile_y_value;
    push_data.sum_x       = wsx_nxt;
    push_data.sum_y       = wsy_nxt;
    push_data.energy_sum  = esum_nxt;
    push_data.seed_x      = seed_x_nxt;
    push_data.seed_y      = seed_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      wsx_r    <= '0;
      wsy_r    <= '0;
      esum_r   <= '0;
      seed_e_r <= '0;
      seed_x_r <= '0;
      seed_y_r <= '0;
      first_r  <= 1'b1;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            item_r  <= in_data;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          prodx_r <= item_r.block_x * $signed({1'b0, item_r.block_energy});
          prody_r <= item_r.block_y * $signed({1'b0, item_r.block_energy});
          state_r <= F_ACC;
        end
        F_ACC: begin
          if (item_r.mode) begin
            if (item_r.last_block) begin
              wsx_r    <= '0;
              wsy_r    <= '0;
              esum_r   <= '0;
              seed_e_r <= '0;
              seed_x_r <= '0;
              seed_y_r <= '0;
              first_r  <= 1'b1;
            end else begin
              wsx_r    <= wsx_nxt;
              wsy_r    <= wsy_nxt;
              esum_r   <= esum_nxt;
              seed_e_r <= take ? item_r.block_energy : seed_e_r;
              seed_x_r <= seed_x_nxt;
              seed_y_r <= seed_y_nxt;
              first_r  <= 1'b0;
            end
          end
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/spc_div.sv -----
// ----------------------------------------------------------------------------
// spc_div
// Radix-2 restoring divider, one quotient bit per cycle, floor quotient for a
// sign and magnitude numerator over a positive divisor.
// ----------------------------------------------------------------------------
module spc_div
  import spc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     neg,
  input  logic [DIV_NW-1:0]        mag,
  input  logic [DIV_DW-1:0]        den,
  output logic                     done,
  output logic signed [DIV_NW:0]   quot,
  output logic [DIV_DW-1:0]        rem
);

  logic              busy_r, done_r, neg_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] acc_r, den_r;
  logic [DIV_NW-1:0] q_r;

  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW-1:0] acc_nxt;
  logic [DIV_NW:0]   qext;

  assign trial   = {acc_r, q_r[DIV_NW-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign acc_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
  assign qext    = {1'b0, q_r};

  assign done = done_r;
  assign rem  = acc_r;
  assign quot = !neg_r ? $signed(qext) :
                (acc_r != '0) ? $signed(~qext) : $signed(-qext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        q_r    <= mag;
        neg_r  <= neg;
        den_r  <= den;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        q_r   <= {q_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/spc_back.sv -----
// ----------------------------------------------------------------------------
// spc_back
// Back end: applies table writes, and for each finished cluster forms the
// moments, segment and bins, interpolates the profiles and drives the result.
// ----------------------------------------------------------------------------
module spc_back
  import spc_pkg::*;
#(
  parameter int SEGMENTS_X   = 1,
  parameter int SEGMENTS_Y   = 1,
  parameter int PROFILE_BINS = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  output logic             q_pop,
  input  job_t             q_data,
  output tbl_port_t        tbl,
  input  logic [VAL_W-1:0] rdata_x,
  input  logic [VAL_W-1:0] rdata_y,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int BIN_W = $clog2(PROFILE_BINS);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_CHECK, ST_SEGX, ST_SEGY, ST_MOMX, ST_MOMY, ST_MCHK,
    ST_BINX, ST_BINY, ST_RDH, ST_RDL, ST_RDW, ST_INTX, ST_INTY, ST_FIN1,
    ST_FIN2, ST_OUT
  } bstate_t;

  bstate_t             state_r;
  logic                go_r;
  job_t                job_r;
  logic signed [47:0]  pxs_r, pys_r;
  logic [43:0]         dx_r, dy_r;
  logic signed [20:0]  offx_r, offy_r, spx_r, spy_r;
  logic signed [60:0]  numx_r, numy_r;
  logic signed [61:0]  momx_r, momy_r;
  logic [15:0]         moffx_r, moffy_r;
  logic signed [16:0]  mspan_r;
  logic [SEG_W-1:0]    segx_r, segy_r;
  logic [BIN_W-1:0]    binx_r, biny_r;
  logic [15:0]         remx_r, remy_r;
  logic [15:0]         hix_r, hiy_r, lox_r, loy_r;
  logic [15:0]         fx_r, fy_r;
  logic signed [33:0]  tx_r, ty_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic                div_neg, div_done;
  logic [DIV_NW-1:0]   div_mag;
  logic [DIV_DW-1:0]   div_den;
  logic signed [DIV_NW:0] div_quot;
  logic [DIV_DW-1:0]   div_rem;

  logic signed [16:0]  mspan;
  logic signed [62:0]  moffx, moffy;
  logic                okx, oky, mokx, moky;
  logic signed [16:0]  dlx, dly;
  logic signed [33:0]  nix, niy;
  logic [7:0]          seg;
  logic [31:0]         sumx, sumy;
  logic signed [17:0]  fxs, fys;
  logic signed [16:0]  hx, hy;

  spc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .neg   (div_neg),
    .mag   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  assign okx   = (spx_r > 0) && (offx_r >= 0) && (offx_r < spx_r);
  assign oky   = (spy_r > 0) && (offy_r >= 0) && (offy_r < spy_r);
  assign mspan = 17'(cfg.moment_max) - 17'(cfg.moment_min);
  assign moffx = 63'(momx_r) - 63'(cfg.moment_min);
  assign moffy = 63'(momy_r) - 63'(cfg.moment_min);
  assign mokx  = (mspan > 0) && (moffx >= 0) && (moffx < 63'(mspan));
  assign moky  = (mspan > 0) && (moffy >= 0) && (moffy < 63'(mspan));
  assign dlx   = $signed({1'b0, hix_r}) - $signed({1'b0, lox_r});
  assign dly   = $signed({1'b0, hiy_r}) - $signed({1'b0, loy_r});
  assign nix   = dlx * $signed({1'b0, remx_r});
  assign niy   = dly * $signed({1'b0, remy_r});
  assign seg   = {4'b0, segy_r} + 8'(SEGMENTS_Y) * {4'b0, segx_r};
  assign sumx  = 32'(seg) * 32'(PROFILE_BINS) + 32'(binx_r);
  assign sumy  = 32'(seg) * 32'(PROFILE_BINS) + 32'(biny_r);
  assign fxs   = $signed({2'b0, lox_r}) + div_quot[17:0];
  assign fys   = $signed({2'b0, loy_r}) + div_quot[17:0];
  assign hx    = $signed({1'b0, fx_r}) - HALF_Q16;
  assign hy    = $signed({1'b0, fy_r}) - HALF_Q16;

  always_comb begin
    div_neg = 1'b0;
    div_mag = '0;
    div_den = '0;
    unique case (state_r)
      ST_SEGX: begin
        div_mag = DIV_NW'(offx_r[19:0]) * DIV_NW'(SEGMENTS_X);
        div_den = DIV_DW'(spx_r[19:0]);
      end
      ST_SEGY: begin
        div_mag = DIV_NW'(offy_r[19:0]) * DIV_NW'(SEGMENTS_Y);
        div_den = DIV_DW'(spy_r[19:0]);
      end
      ST_MOMX: begin
        div_neg = numx_r[60];
        div_mag = numx_r[60] ? DIV_NW'(-numx_r) : DIV_NW'(numx_r);
        div_den = dx_r;
      end
      ST_MOMY: begin
        div_neg = numy_r[60];
        div_mag = numy_r[60] ? DIV_NW'(-numy_r) : DIV_NW'(numy_r);
        div_den = dy_r;
      end
      ST_BINX: begin
        div_mag = DIV_NW'(moffx_r) * DIV_NW'(PROFILE_BINS);
        div_den = DIV_DW'(mspan_r[15:0]);
      end
      ST_BINY: begin
        div_mag = DIV_NW'(moffy_r) * DIV_NW'(PROFILE_BINS);
        div_den = DIV_DW'(mspan_r[15:0]);
      end
      ST_INTX: begin
        div_neg = nix[33];
        div_mag = nix[33] ? DIV_NW'(-nix) : DIV_NW'(nix);
        div_den = DIV_DW'(mspan_r[15:0]);
      end
      ST_INTY: begin
        div_neg = niy[33];
        div_mag = niy[33] ? DIV_NW'(-niy) : DIV_NW'(niy);
        div_den = DIV_DW'(mspan_r[15:0]);
      end
      default: begin
        div_neg = 1'b0;
      end
    endcase
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    tbl         = '0;
    tbl.we      = q_pop && q_data.is_write;
    tbl.waddr   = q_data.table_index;
    tbl.wdata_x = q_data.px;
    tbl.wdata_y = q_data.py;
    if (state_r == ST_RDL) begin
      tbl.raddr_x = TABLE_AW'(sumx - 32'd1);
      tbl.raddr_y = TABLE_AW'(sumy - 32'd1);
    end else begin
      tbl.raddr_x = sumx[TABLE_AW-1:0];
      tbl.raddr_y = sumy[TABLE_AW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && !q_data.is_write) begin
            job_r   <= q_data;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          pxs_r   <= job_r.seed_x * $signed({1'b0, job_r.energy_sum});
          pys_r   <= job_r.seed_y * $signed({1'b0, job_r.energy_sum});
          dx_r    <= job_r.energy_sum * cfg.cell_width_x;
          dy_r    <= job_r.energy_sum * cfg.cell_width_y;
          offx_r  <= 21'(job_r.seed_x) - 21'(cfg.seed_x_min);
          offy_r  <= 21'(job_r.seed_y) - 21'(cfg.seed_y_min);
          spx_r   <= 21'(cfg.seed_x_max) - 21'(cfg.seed_x_min);
          spy_r   <= 21'(cfg.seed_y_max) - 21'(cfg.seed_y_min);
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          numx_r            <= (61'(job_r.sum_x) - 61'(pxs_r)) <<< 12;
          numy_r            <= (61'(job_r.sum_y) - 61'(pys_r)) <<< 12;
          out_r.corrected_x <= '0;
          out_r.corrected_y <= '0;
          if (job_r.energy_sum == '0) begin
            out_r.status <= STAT_ZERO;
            out_valid_r  <= 1'b1;
            state_r      <= ST_OUT;
          end else if (!(okx && oky)) begin
            out_r.status <= STAT_SEED;
            out_valid_r  <= 1'b1;
            state_r      <= ST_OUT;
          end else if (cfg.cell_width_x == '0 || cfg.cell_width_y == '0) begin
            out_r.status <= STAT_MOMENT;
            out_valid_r  <= 1'b1;
            state_r      <= ST_OUT;
          end else begin
            go_r    <= 1'b1;
            state_r <= ST_SEGX;
          end
        end
        ST_SEGX: begin
          if (div_done) begin
            segx_r  <= div_quot[SEG_W-1:0];
            go_r    <= 1'b1;
            state_r <= ST_SEGY;
          end
        end
        ST_SEGY: begin
          if (div_done) begin
            segy_r  <= div_quot[SEG_W-1:0];
            go_r    <= 1'b1;
            state_r <= ST_MOMX;
          end
        end
        ST_MOMX: begin
          if (div_done) begin
            momx_r  <= div_quot;
            go_r    <= 1'b1;
            state_r <= ST_MOMY;
          end
        end
        ST_MOMY: begin
          if (div_done) begin
            momy_r  <= div_quot;
            state_r <= ST_MCHK;
          end
        end
        ST_MCHK: begin
          moffx_r <= moffx[15:0];
          moffy_r <= moffy[15:0];
          mspan_r <= mspan;
          if (mokx && moky) begin
            go_r    <= 1'b1;
            state_r <= ST_BINX;
          end else begin
            out_r.status <= STAT_MOMENT;
            out_valid_r  <= 1'b1;
            state_r      <= ST_OUT;
          end
        end
        ST_BINX: begin
          if (div_done) begin
            binx_r  <= div_quot[BIN_W-1:0];
            remx_r  <= div_rem[15:0];
            go_r    <= 1'b1;
            state_r <= ST_BINY;
          end
        end
        ST_BINY: begin
          if (div_done) begin
            biny_r  <= div_quot[BIN_W-1:0];
            remy_r  <= div_rem[15:0];
            state_r <= ST_RDH;
          end
        end
        ST_RDH: begin
          state_r <= ST_RDL;
        end
        ST_RDL: begin
          hix_r   <= rdata_x;
          hiy_r   <= rdata_y;
          state_r <= ST_RDW;
        end
        ST_RDW: begin
          lox_r   <= (binx_r == '0) ? hix_r : rdata_x;
          loy_r   <= (biny_r == '0) ? hiy_r : rdata_y;
          go_r    <= 1'b1;
          state_r <= ST_INTX;
        end
        ST_INTX: begin
          if (div_done) begin
            fx_r    <= fxs[15:0];
            go_r    <= 1'b1;
            state_r <= ST_INTY;
          end
        end
        ST_INTY: begin
          if (div_done) begin
            fy_r    <= fys[15:0];
            state_r <= ST_FIN1;
          end
        end
        ST_FIN1: begin
          tx_r    <= hx * $signed({1'b0, cfg.cell_width_x});
          ty_r    <= hy * $signed({1'b0, cfg.cell_width_y});
          state_r <= ST_FIN2;
        end
        ST_FIN2: begin
          out_r.corrected_x <= sat20(21'(job_r.seed_x) + 21'(tx_r >>> 16));
          out_r.corrected_y <= sat20(21'(job_r.seed_y) + 21'(ty_r >>> 16));
          out_r.status      <= STAT_OK;
          out_valid_r       <= 1'b1;
          state_r           <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
